FILE: sv/grid_box_partition_assert.svh
// assertion macros shared by the grid box partition checks
// no dependencies; include by bare file name
`ifndef GRID_BOX_PARTITION_ASSERT_SVH
`define GRID_BOX_PARTITION_ASSERT_SVH

// immediate implication: cond holds whenever pre holds, outside reset
`define GBP_ASSERT_NOW(lbl, clk, rst_n, pre, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (cond)) \
		else $error("grid_box_partition check failed");

// next-cycle implication: cond holds in the cycle after pre
`define GBP_ASSERT_NEXT(lbl, clk, rst_n, pre, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (cond)) \
		else $error("grid_box_partition check failed");

`endif

FILE: sv/gbp_pkg.sv
// shared constants for the grid box partition block
// no dependencies
package gbp_pkg;

	// width of every payload field and of the processor count register
	localparam int FIELD_W = 16;

endpackage

FILE: sv/grid_box_partition.sv
// grid box partition: chooses a box lattice for a grid and the box sizes
// depends on gbp_pkg
//
// One grid (width, height) is taken per beat and one result beat is given back. The box
// target is proc_count (zero counts as one), capped at width * height. The block starts
// from a 1 x 1 split and adds one cut per cycle, along x while width * parts_y >=
// height * parts_x and x can still be cut, or y can no longer be cut, else along y, until
// parts_x * parts_y reaches the target. Both box sizes then come from one shared restoring
// divider, one quotient bit per cycle. Each item runs through the cut loop and then the
// division for x and then the one for y. in_stall is high from the accepting edge until the
// work is finished; the finished result sits in an output register, so a new grid may be
// taken while the previous result waits. proc_count is written through cfg_we / cfg_wdata;
// the user must write it only while the block is idle; the block itself does not enforce this.
module grid_box_partition #(
	parameter int EXTENT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gbp_pkg::FIELD_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [gbp_pkg::FIELD_W-1:0]  grid_width,
	input  logic [gbp_pkg::FIELD_W-1:0]  grid_height,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gbp_pkg::FIELD_W-1:0]  parts_x,
	output logic [gbp_pkg::FIELD_W-1:0]  parts_y,
	output logic [gbp_pkg::FIELD_W-1:0]  box_width,
	output logic [gbp_pkg::FIELD_W-1:0]  box_height
);

	localparam int FW = gbp_pkg::FIELD_W;
	// extents are taken in their low EXTENT_BITS bits, never more than the field
	localparam int EW = (EXTENT_BITS < FW) ? EXTENT_BITS : FW;
	// products and the target share one width
	localparam int MW = (2 * EW > FW) ? 2 * EW : FW;
	localparam int CW = $clog2(EW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CAP,
		ST_CUT,
		ST_DIV_X,
		ST_DIV_Y,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [FW-1:0]   pc_q;
	logic [EW-1:0]   w_q, h_q, px_q, py_q;
	logic [MW-1:0]   cells_q, target_q, prod_q, wpy_q, hpx_q;
	logic [EW-1:0]   dvd_q, dvs_q, bw_q, bh_q;
	logic [EW-1:0]   rem_q;
	logic [CW-1:0]   cnt_q;
	logic            out_valid_q;
	logic [FW-1:0]   out_px_q, out_py_q, out_bw_q, out_bh_q;

	logic [FW-1:0]   pc_eff;
	logic [MW-1:0]   target_nx;
	logic            cut_done, x_wider, cut_x, cut_y;
	logic [EW:0]     trial;
	logic [EW-1:0]   rem_nx;
	logic            fits, div_last;
	logic [EW-1:0]   dvd_nx, ceil_nx;

	always_comb begin
		pc_eff    = (pc_q == '0) ? FW'(1) : pc_q;
		target_nx = (MW'(pc_eff) > cells_q) ? cells_q : MW'(pc_eff);

		cut_done = prod_q >= target_q;
		x_wider  = wpy_q >= hpx_q;
		cut_x    = (x_wider && (px_q < w_q)) || (py_q >= h_q);
		cut_y    = py_q < h_q;

		// one restoring division step
		trial    = {rem_q, dvd_q[EW-1]};
		fits     = trial >= {1'b0, dvs_q};
		rem_nx   = fits ? EW'(trial - {1'b0, dvs_q}) : trial[EW-1:0];
		dvd_nx   = {dvd_q[EW-2:0], fits};
		ceil_nx  = dvd_nx + EW'(rem_nx != '0);
		div_last = cnt_q == CW'(EW - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= FW'(1);
			out_valid_q <= 1'b0;
			w_q         <= '0;
			h_q         <= '0;
			px_q        <= '0;
			py_q        <= '0;
			cells_q     <= '0;
			target_q    <= '0;
			prod_q      <= '0;
			wpy_q       <= '0;
			hpx_q       <= '0;
			dvd_q       <= '0;
			dvs_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			bw_q        <= '0;
			bh_q        <= '0;
			out_px_q    <= '0;
			out_py_q    <= '0;
			out_bw_q    <= '0;
			out_bh_q    <= '0;
		end else begin
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						w_q     <= grid_width[EW-1:0];
						h_q     <= grid_height[EW-1:0];
						px_q    <= EW'(1);
						py_q    <= EW'(1);
						prod_q  <= MW'(1);
						wpy_q   <= MW'(grid_width[EW-1:0]);
						hpx_q   <= MW'(grid_height[EW-1:0]);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cells_q <= MW'(w_q) * MW'(h_q);
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					target_q <= target_nx;
					state_q  <= ST_CUT;
				end
				ST_CUT: begin
					if (cut_done || (!cut_x && !cut_y)) begin
						dvd_q   <= w_q;
						dvs_q   <= px_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV_X;
					end else if (cut_x) begin
						px_q   <= px_q + EW'(1);
						prod_q <= prod_q + MW'(py_q);
						hpx_q  <= hpx_q + MW'(h_q);
					end else begin
						py_q   <= py_q + EW'(1);
						prod_q <= prod_q + MW'(px_q);
						wpy_q  <= wpy_q + MW'(w_q);
					end
				end
				ST_DIV_X: begin
					dvd_q <= dvd_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + CW'(1);
					if (div_last) begin
						bw_q    <= ceil_nx;
						dvd_q   <= h_q;
						dvs_q   <= py_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV_Y;
					end
				end
				ST_DIV_Y: begin
					dvd_q <= dvd_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + CW'(1);
					if (div_last) begin
						bh_q    <= ceil_nx;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// wait for the output register to free up
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_px_q    <= FW'(px_q);
						out_py_q    <= FW'(py_q);
						out_bw_q    <= FW'(bw_q);
						out_bh_q    <= FW'(bh_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = state_q != ST_IDLE;
	assign out_valid  = out_valid_q;
	assign parts_x    = out_px_q;
	assign parts_y    = out_py_q;
	assign box_width  = out_bw_q;
	assign box_height = out_bh_q;

endmodule

FILE: sv/gbp_checker.sv
// port-level checks for grid_box_partition, attached by bind
// depends on gbp_pkg and grid_box_partition_assert.svh
`include "grid_box_partition_assert.svh"

module gbp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [gbp_pkg::FIELD_W-1:0]  parts_x,
	input logic [gbp_pkg::FIELD_W-1:0]  parts_y,
	input logic [gbp_pkg::FIELD_W-1:0]  box_width,
	input logic [gbp_pkg::FIELD_W-1:0]  box_height
);

	logic [4*gbp_pkg::FIELD_W-1:0] res_all;

	assign res_all = {parts_x, parts_y, box_width, box_height};

	// a stalled result beat stays put
	`GBP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(res_all))

	// the block is busy right after taking a grid
	`GBP_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall)

	// no result can appear in the cycle after a grid is taken
	`GBP_ASSERT_NEXT(a_no_instant_out, clk, arst_n, in_valid && !in_stall, !$rose(out_valid))

	// part counts never drop below one
	`GBP_ASSERT_NOW(a_parts_nonzero, clk, arst_n, out_valid, parts_x != '0 && parts_y != '0)

endmodule

bind grid_box_partition gbp_checker u_gbp_checker (.*);
